// ----- rtl/acr_pkg.sv -----
package acr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int FRAME_BYTES   = 60;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int FIDX_W        = 6;

    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_RESOLVE = 2'd1;
    localparam logic [1:0] FUNC_SEND    = 2'd2;

    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_LEARN   = 2'd1;
    localparam logic [1:0] KIND_RESOLVE = 2'd2;

    localparam logic [1:0] CFG_HOST_MAC = 2'd0;
    localparam logic [1:0] CFG_HOST_IP  = 2'd1;
    localparam logic [1:0] CFG_MASK     = 2'd2;
    localparam logic [1:0] CFG_GATEWAY  = 2'd3;

    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic        added;
        logic        table_full;
        logic        found;
        logic [31:0] hop_ip;
        logic [47:0] hop_mac;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_FRAME,
        ST_SINGLE
    } state_t;

    function automatic logic [7:0] frame_byte_at(
        input logic [5:0]  i,
        input logic [47:0] dst,
        input logic [47:0] smac,
        input logic [7:0]  op,
        input logic [31:0] sip,
        input logic [47:0] tha,
        input logic [31:0] tpa
    );
        logic [7:0] b;
        b = 8'h00;
        if (i < 6'd6)       b = dst[8*(5 - (i - 6'd0)) +: 8];
        else if (i < 6'd12) b = smac[8*(5 - (i - 6'd6)) +: 8];
        else if (i == 6'd12) b = 8'h08;
        else if (i == 6'd13) b = 8'h06;
        else if (i == 6'd15) b = 8'h01;
        else if (i == 6'd16) b = 8'h08;
        else if (i == 6'd18) b = 8'h06;
        else if (i == 6'd19) b = 8'h04;
        else if (i == 6'd21) b = op;
        else if (i >= 6'd22 && i < 6'd28) b = smac[8*(5 - (i - 6'd22)) +: 8];
        else if (i >= 6'd28 && i < 6'd32) b = sip[8*(3 - (i - 6'd28)) +: 8];
        else if (i >= 6'd32 && i < 6'd38) b = tha[8*(5 - (i - 6'd32)) +: 8];
        else if (i >= 6'd38 && i < 6'd42) b = tpa[8*(3 - (i - 6'd38)) +: 8];
        return b;
    endfunction

endpackage

// ----- rtl/acr_table.sv -----
module acr_table
    import acr_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_ip,
    input  logic [47:0]      wr_mac,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_ip,
    output logic [47:0]      rd_mac
);

    logic [79:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_ip, wr_mac};
        end
        {rd_ip, rd_mac} <= mem[rd_addr];
    end

endmodule

// ----- rtl/arp_cache_responder.sv -----
// a lookup reads the cache one entry per cycle up to a hit or the entry count
// before the learn status or resolve answer; a frame then streams 60 bytes
// one request at a time: the input stalls until the last response of a request is taken
// the entry count sets the scan length, the byte counter the frame length
// reset: entry count and state clear, registers take their defaults, cache
// contents stay undefined and are never read before being written
module arp_cache_responder
    import acr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // configuration registers
    logic [47:0] host_mac_reg;
    logic [31:0] host_ip_reg, mask_reg, gw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_mac_reg <= '0;
            host_ip_reg  <= 32'd167772687;
            mask_reg     <= 32'hFFFF_FF00;
            gw_reg       <= 32'd167772673;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HOST_MAC: host_mac_reg <= cfg_data;
                CFG_HOST_IP:  host_ip_reg  <= cfg_data[31:0];
                CFG_MASK:     mask_reg     <= cfg_data[31:0];
                CFG_GATEWAY:  gw_reg       <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [31:0]      key_reg, key_next;        // ip being searched
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;      // entries issued so far
    logic             hit_reg, hit_next;
    logic [47:0]      hit_mac_reg, hit_mac_next;
    logic             added_reg, added_next, full_reg, full_next;
    logic [FIDX_W-1:0] fidx_reg, fidx_next;
    logic             chk_reg, chk_next;        // read data valid next cycle

    logic [31:0] rd_ip;
    logic [47:0] rd_mac;
    logic        wr_en;

    wire is_rx  = req_reg.func == FUNC_RX;
    wire is_req = req_reg.arp_opcode == OP_REQUEST;
    wire in_acc = in_valid && !in_stall;
    wire out_acc = out_valid && !out_stall;

    assign in_stall = state_reg != ST_IDLE;

    acr_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_ip   (req_reg.sender_ip),
        .wr_mac  (req_reg.sender_mac),
        .rd_addr (scan_reg[IDX_W-1:0]),
        .rd_ip   (rd_ip),
        .rd_mac  (rd_mac)
    );

    // next hop choice for resolve queries
    logic [31:0] hop;
    always_comb
    begin
        hop = ((in_data.target_ip & mask_reg) == (host_ip_reg & mask_reg))
              ? in_data.target_ip : gw_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        hit_next     = hit_reg;
        hit_mac_next = hit_mac_reg;
        added_next   = added_reg;
        full_next    = full_reg;
        fidx_next    = fidx_reg;
        chk_next     = 1'b0;
        wr_en        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    added_next = 1'b0;
                    full_next  = 1'b0;
                    fidx_next  = '0;
                    key_next   = (in_data.func == FUNC_RX) ? in_data.sender_ip : hop;
                    priority case (1'b1)
                        in_data.func == FUNC_RX &&
                        (in_data.arp_opcode == OP_REQUEST ||
                         in_data.arp_opcode == OP_REPLY): state_next = ST_SCAN;
                        in_data.func == FUNC_RESOLVE:     state_next = ST_SCAN;
                        in_data.func == FUNC_SEND:        state_next = ST_FRAME;
                        default:                          state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // a hit on the entry read last cycle stops the walk
                if (chk_reg && rd_ip == key_reg)
                begin
                    hit_next     = 1'b1;
                    hit_mac_next = rd_mac;
                    state_next   = ST_DECIDE;
                end
                else if (scan_reg < count_reg)
                begin
                    scan_next = scan_reg + 1'b1;
                    chk_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (is_rx)
                begin
                    if (!hit_reg)
                    begin
                        if (count_reg < CNT_W'(TABLE_ENTRIES))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            added_next = 1'b1;
                        end
                        else
                        begin
                            full_next = 1'b1;
                        end
                    end
                    state_next = is_req ? ST_FRAME : ST_SINGLE;
                end
                else
                begin
                    state_next = ST_SINGLE;
                end
            end
            ST_FRAME:
            begin
                if (out_acc)
                begin
                    if (fidx_reg == FIDX_W'(FRAME_BYTES - 1))
                    begin
                        fidx_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fidx_next = fidx_reg + 1'b1;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (out_acc)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result assembly
    always_comb
    begin
        out_valid = 1'b0;
        out_data  = '0;
        unique case (state_reg)
            ST_FRAME:
            begin
                out_valid           = 1'b1;
                out_data.kind       = KIND_FRAME;
                out_data.frame_last = fidx_reg == FIDX_W'(FRAME_BYTES - 1);
                out_data.added      = added_reg;
                out_data.table_full = full_reg;
                if (is_rx)
                begin
                    out_data.frame_byte = frame_byte_at(fidx_reg, req_reg.sender_mac,
                        host_mac_reg, 8'd2, host_ip_reg, req_reg.sender_mac,
                        req_reg.sender_ip);
                end
                else
                begin
                    out_data.frame_byte = frame_byte_at(fidx_reg, BCAST_MAC,
                        host_mac_reg, 8'd1, host_ip_reg, 48'd0, req_reg.target_ip);
                end
            end
            ST_SINGLE:
            begin
                out_valid = 1'b1;
                if (is_rx)
                begin
                    out_data.kind       = KIND_LEARN;
                    out_data.added      = added_reg;
                    out_data.table_full = full_reg;
                end
                else
                begin
                    out_data.kind    = KIND_RESOLVE;
                    out_data.found   = hit_reg;
                    out_data.hop_ip  = key_reg;
                    out_data.hop_mac = hit_reg ? hit_mac_reg : 48'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            fidx_reg  <= '0;
            chk_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            added_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
            fidx_reg  <= fidx_next;
            chk_reg   <= chk_next;
            hit_reg   <= hit_next;
            added_reg <= added_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= in_data;
        end
        key_reg     <= key_next;
        hit_mac_reg <= hit_mac_next;
    end

    // cache never holds more than its size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count over table size");

    // the scan never reads beyond the filled part
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= count_reg)
        else $error("scan past entry count");

    // a learn always writes into a free slot and bumps the count
    a_learn: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("learn without count update");

    // the byte counter is idle outside frame output
    a_fidx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> fidx_reg == '0)
        else $error("frame index not cleared");

endmodule

// ----- sim/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    req_t        in_data;
    logic        out_valid;
    logic        out_stall;
    rsp_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;

    arp_cache_responder DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor copy of the registers and the cache
    logic [47:0] mdl_host_mac;
    logic [31:0] mdl_host_ip;
    logic [31:0] mdl_mask;
    logic [31:0] mdl_gateway;
    logic [31:0] cache_ip [TABLE_ENTRIES];
    logic [47:0] cache_mac [TABLE_ENTRIES];
    int          cache_count;

    // responses still owed by the block, oldest first
    rsp_t        pending_rsp [$];
    int          mismatches;
    int          unexpected;
    bit          hold_off;

    // receiver back-pressure mode: 0 random pattern, 1 never stall
    int          stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous time limit
    initial
    begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

    function automatic int cache_lookup(input logic [31:0] ip);
        for (int i = 0; i < cache_count; i++)
            if (cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // byte i of an outgoing frame, built from the predictor's registers
    function automatic logic [7:0] wire_byte(input int i, input logic [47:0] dst,
                                             input logic [7:0] op,
                                             input logic [47:0] tha,
                                             input logic [31:0] tpa);
        logic [7:0] hdr [42];
        for (int k = 0; k < 6; k++)
        begin
            hdr[k]      = dst[8*(5-k) +: 8];
            hdr[6+k]    = mdl_host_mac[8*(5-k) +: 8];
            hdr[22+k]   = mdl_host_mac[8*(5-k) +: 8];
            hdr[32+k]   = tha[8*(5-k) +: 8];
        end
        for (int k = 0; k < 4; k++)
        begin
            hdr[28+k] = mdl_host_ip[8*(3-k) +: 8];
            hdr[38+k] = tpa[8*(3-k) +: 8];
        end
        hdr[12] = 8'h08; hdr[13] = 8'h06; hdr[14] = 8'h00; hdr[15] = 8'h01;
        hdr[16] = 8'h08; hdr[17] = 8'h00; hdr[18] = 8'd6;  hdr[19] = 8'd4;
        hdr[20] = 8'h00; hdr[21] = op;
        return (i < 42) ? hdr[i] : 8'h00;
    endfunction

    task automatic queue_frame(input logic [47:0] dst, input logic [7:0] op,
                               input logic [47:0] tha, input logic [31:0] tpa,
                               input logic added, input logic full);
        rsp_t r;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            r = '0;
            r.kind       = KIND_FRAME;
            r.frame_byte = wire_byte(i, dst, op, tha, tpa);
            r.frame_last = (i == FRAME_BYTES - 1);
            r.added      = added;
            r.table_full = full;
            pending_rsp.push_back(r);
        end
    endtask

    // work out the responses one accepted request causes
    task automatic predict_arp(input req_t q);
        rsp_t        r;
        logic        added;
        logic        full;
        logic [31:0] hop;
        int          idx;
        added = 1'b0;
        full  = 1'b0;
        r     = '0;
        case (q.func)
            FUNC_RX:
            begin
                if (q.arp_opcode == OP_REQUEST || q.arp_opcode == OP_REPLY)
                begin
                    if (cache_lookup(q.sender_ip) < 0)
                    begin
                        if (cache_count < TABLE_ENTRIES)
                        begin
                            cache_ip[cache_count]  = q.sender_ip;
                            cache_mac[cache_count] = q.sender_mac;
                            cache_count++;
                            added = 1'b1;
                        end
                        else
                            full = 1'b1;
                    end
                    if (q.arp_opcode == OP_REQUEST)
                        queue_frame(q.sender_mac, OP_REPLY[7:0], q.sender_mac,
                                    q.sender_ip, added, full);
                    else
                    begin
                        r.kind       = KIND_LEARN;
                        r.added      = added;
                        r.table_full = full;
                        pending_rsp.push_back(r);
                    end
                end
            end
            FUNC_RESOLVE:
            begin
                hop = ((q.target_ip & mdl_mask) == (mdl_host_ip & mdl_mask))
                      ? q.target_ip : mdl_gateway;
                idx = cache_lookup(hop);
                r.kind   = KIND_RESOLVE;
                r.found  = (idx >= 0);
                r.hop_ip = hop;
                r.hop_mac = (idx >= 0) ? cache_mac[idx] : 48'h0;
                pending_rsp.push_back(r);
            end
            FUNC_SEND:
                queue_frame(BCAST_MAC, OP_REQUEST[7:0], 48'h0, q.target_ip, 1'b0, 1'b0);
            default: ;
        endcase
    endtask

    // response checker, sampled at the edge where the response is taken
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected response %h", out_data);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (out_data !== want)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: exp kind %0d byte %h last %b add %b full %b found %b ip %h mac %h / got kind %0d byte %h last %b add %b full %b found %b ip %h mac %h",
                                 want.kind, want.frame_byte, want.frame_last, want.added,
                                 want.table_full, want.found, want.hop_ip, want.hop_mac,
                                 out_data.kind, out_data.frame_byte, out_data.frame_last,
                                 out_data.added, out_data.table_full, out_data.found,
                                 out_data.hop_ip, out_data.hop_mac);
                end
            end
        end
    end

    // receiver stall pattern; a long hold-off forces the block to back up
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off)
            out_stall <= 1'b1;
        else if (stall_mode == 1)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        stall_mode = 0;
        forever
        begin
            repeat ($urandom_range(100, 600)) @(posedge clk);
            stall_mode = $urandom_range(0, 1);
        end
    end

    // register write while idle; valid drops once the write is taken
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HOST_MAC: mdl_host_mac = val;
            CFG_HOST_IP:  mdl_host_ip  = val[31:0];
            CFG_MASK:     mdl_mask     = val[31:0];
            default:      mdl_gateway  = val[31:0];
        endcase
        @(posedge clk);
    endtask

    // wait for all owed responses, then let the block settle
    task automatic drain_all();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // send one request, holding it steady until taken
    task automatic send_req(input req_t q);
        in_valid <= 1'b1;
        in_data  <= q;
        do @(posedge clk); while (in_stall);
        predict_arp(q);
    endtask

    // gap between bursts, lowering valid only when a gap is wanted
    int burst_left;
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    endtask

    function automatic logic [31:0] rand_ip();
        return $urandom;
    endfunction

    function automatic logic [47:0] rand_mac();
        return 48'({$urandom, $urandom});
    endfunction

    // random request, mostly well-formed, biased toward the local subnet
    // and toward addresses already cached
    function automatic req_t rand_req();
        req_t q;
        int   sel;
        q = '0;
        q.sender_mac = rand_mac();
        q.sender_ip  = (cache_count > 0 && $urandom_range(0, 3) == 0)
                       ? cache_ip[$urandom_range(0, cache_count - 1)]
                       : ((mdl_host_ip & mdl_mask) | (rand_ip() & ~mdl_mask));
        if ($urandom_range(0, 5) == 0)
            q.sender_ip = rand_ip();
        q.target_ip = (cache_count > 0 && $urandom_range(0, 2) == 0)
                      ? cache_ip[$urandom_range(0, cache_count - 1)]
                      : ((mdl_host_ip & mdl_mask) | (rand_ip() & ~mdl_mask));
        if ($urandom_range(0, 4) == 0)
            q.target_ip = rand_ip();
        sel = $urandom_range(0, 19);
        if (sel < 6)
        begin
            q.func = FUNC_RX;
            q.arp_opcode = OP_REPLY;
        end
        else if (sel < 8)
        begin
            q.func = FUNC_RX;
            q.arp_opcode = OP_REQUEST;
        end
        else if (sel < 16)
            q.func = FUNC_RESOLVE;
        else if (sel < 17)
            q.func = FUNC_SEND;
        else if (sel < 19)
        begin
            // ignored opcodes and the unused function code
            q.func = FUNC_RX;
            q.arp_opcode = 16'($urandom);
        end
        else
        begin
            q.func = 2'd3;
            q.arp_opcode = 16'($urandom);
        end
        return q;
    endfunction

    // directed table: function, opcode, sender mac, sender ip, target ip,
    // and for the few rows readable at a glance, the typed-in response
    typedef struct {
        req_t q;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic req_t mk(input logic [1:0] f, input logic [15:0] op,
                                input logic [47:0] smac, input logic [31:0] sip,
                                input logic [31:0] tip);
        req_t q;
        q.func = f; q.arp_opcode = op; q.sender_mac = smac;
        q.sender_ip = sip; q.target_ip = tip;
        return q;
    endfunction

    function automatic rsp_t mk_learn(input logic added, input logic full);
        rsp_t r;
        r = '0;
        r.kind = KIND_LEARN; r.added = added; r.table_full = full;
        return r;
    endfunction

    function automatic rsp_t mk_miss(input logic [31:0] hop);
        rsp_t r;
        r = '0;
        r.kind = KIND_RESOLVE; r.hop_ip = hop;
        return r;
    endfunction

    initial
    begin
        dir_row_t row;
        rsp_t     got;
        int       lone;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_HOST_MAC;
        cfg_data   = '0;
        hold_off   = 1'b0;
        mismatches = 0;
        unexpected = 0;
        burst_left = 0;
        cache_count = 0;
        mdl_host_mac = 48'h0;
        mdl_host_ip  = 32'd167772687;
        mdl_mask     = 32'd4294967040;
        mdl_gateway  = 32'd167772673;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: empty cache, default gateway and subnet
        dir_rows.push_back('{mk(FUNC_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0A00_0233), 1'b1,
                             mk_miss(32'h0A00_0233)});
        dir_rows.push_back('{mk(FUNC_RESOLVE, 16'h0, 48'h0, 32'h0, 32'hC0A8_0001), 1'b1,
                             mk_miss(32'h0A00_0201)});
        dir_rows.push_back('{mk(FUNC_SEND, 16'h0, 48'h0, 32'h0, 32'h0A00_0202), 1'b0, '0});
        // learn with reply opcode, then a duplicate ip keeps the first entry
        dir_rows.push_back('{mk(FUNC_RX, OP_REPLY, 48'h0011_2233_4455, 32'h0A00_0201,
                                32'h0), 1'b1, mk_learn(1'b1, 1'b0)});
        dir_rows.push_back('{mk(FUNC_RX, OP_REPLY, 48'hFFFF_FFFF_FFFF, 32'h0A00_0201,
                                32'h0), 1'b1, mk_learn(1'b0, 1'b0)});
        dir_rows.push_back('{mk(FUNC_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0808_0808), 1'b0,
                             '0});
        // request opcode: reply frame, learning at the field extremes
        dir_rows.push_back('{mk(FUNC_RX, OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{mk(FUNC_RX, OP_REQUEST, 48'h0, 32'h0, 32'h0), 1'b0, '0});
        // ignored: other opcodes and the unused function code
        dir_rows.push_back('{mk(FUNC_RX, 16'h0000, 48'h1, 32'h1, 32'h0), 1'b0, '0});
        dir_rows.push_back('{mk(FUNC_RX, 16'hFFFF, 48'h2, 32'h2, 32'h0), 1'b0, '0});
        dir_rows.push_back('{mk(2'd3, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF), 1'b0, '0});
        dir_rows.push_back('{mk(FUNC_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0A00_02FF), 1'b0,
                             '0});
        dir_rows.push_back('{mk(FUNC_SEND, 16'h0, 48'h0, 32'h0, 32'hFFFF_FFFF), 1'b0, '0});
        // fill the cache (three entries already learned), then overflow it
        for (int i = 0; i < 13; i++)
            dir_rows.push_back('{mk(FUNC_RX, OP_REPLY, 48'hA000_0000_0000 + i,
                                    32'h0A00_0210 + i, 32'h0), 1'b1,
                                 mk_learn(1'b1, 1'b0)});
        dir_rows.push_back('{mk(FUNC_RX, OP_REPLY, 48'h1, 32'h0A00_0290, 32'h0), 1'b1,
                             mk_learn(1'b0, 1'b1)});
        dir_rows.push_back('{mk(FUNC_RX, OP_REQUEST, 48'h2, 32'h0A00_0291, 32'h0), 1'b0,
                             '0});
        dir_rows.push_back('{mk(FUNC_RESOLVE, 16'h0, 48'h0, 32'h0, 32'h0A00_021D), 1'b0,
                             '0});

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            lone = pending_rsp.size();
            send_req(row.q);
            // a typed-in row replaces the predicted single response
            if (row.typed && pending_rsp.size() == lone + 1)
            begin
                got = pending_rsp.pop_back();
                if (got !== row.want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: typed %h predicted %h", i, row.want, got);
                end
                pending_rsp.push_back(row.want);
            end
            pace();
        end
        in_valid <= 1'b0;
        drain_all();

        // long receiver hold-off while the sender keeps offering requests
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 20; i++)
                    send_req(rand_req());
                in_valid <= 1'b0;
            end
        join
        drain_all();

        // random phases across register settings, extremes among them;
        // the cache persists and is already full, so these phases no longer learn
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(CFG_HOST_MAC, 48'hFFFF_FFFF_FFFF);
                    write_reg(CFG_HOST_IP, 48'(32'hFFFF_FFFF));
                    write_reg(CFG_MASK, 48'(32'hFFFF_FFFF));
                    write_reg(CFG_GATEWAY, 48'(32'hFFFF_FFFF));
                end
                1: begin
                    write_reg(CFG_HOST_MAC, 48'h0);
                    write_reg(CFG_HOST_IP, 48'h0);
                    write_reg(CFG_MASK, 48'h0);
                    write_reg(CFG_GATEWAY, 48'h0);
                end
                default: begin
                    write_reg(CFG_HOST_MAC, rand_mac());
                    write_reg(CFG_HOST_IP,
                              48'(cache_ip[$urandom_range(0, cache_count - 1)]));
                    write_reg(CFG_MASK, 48'(32'hFFFF_FFFF << $urandom_range(0, 32)));
                    write_reg(CFG_GATEWAY,
                              48'(cache_ip[$urandom_range(0, cache_count - 1)]));
                end
            endcase
            for (int i = 0; i < 64; i++)
            begin
                send_req(rand_req());
                pace();
            end
            // sender pauses until every owed response has come
            in_valid <= 1'b0;
            drain_all();
        end

        if (mismatches == 0 && unexpected == 0 && pending_rsp.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- arp_cache_responder.f -----
rtl/acr_pkg.sv
rtl/acr_table.sv
rtl/arp_cache_responder.sv
sim/tb.sv
